[rtl/lfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types, codes and constants of the LED fade, pulse and breath
// envelope block.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int LFP_LEDS    = 3;
    localparam int PULSE_STEPS = 16;

    localparam int LED_W    = 3;
    localparam int MASK_W   = 3;
    localparam int LVL_W    = 8;
    localparam int PULSE_W  = 5;
    localparam int PHASE_W  = 16;
    localparam int DEPTH_W  = 9;
    localparam int CFG_W    = 16;
    localparam int CFG_IDXW = 3;

    localparam int OPW       = 9;
    localparam int PRODW     = 2 * OPW;
    localparam int DVW       = 8;
    localparam int QW        = 16;
    localparam int CNT_W     = 4;
    localparam int MUL_STEPS = OPW;
    localparam int DIV_STEPS = QW;

    localparam logic [LVL_W-1:0]   FULL_SCALE       = 8'd255;
    localparam logic [MASK_W-1:0]  BREATH_MASK_RST  = 3'd0;
    localparam logic [MASK_W-1:0]  PRESS_MASK_RST   = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_STEP_RST   = 16'd218;
    localparam logic [DEPTH_W-1:0] DROP_DEPTH_RST   = 9'd171;
    localparam logic [LVL_W-1:0]   FADE_MAX_RST     = 8'd100;
    localparam logic [PRODW-1:0]   EASE_ROUND       = 18'd64;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_PRESS = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDXW-1:0] {
        CFG_BREATH_MASK = 3'd0,
        CFG_PRESS_MASK  = 3'd1,
        CFG_PHASE_STEP  = 3'd2,
        CFG_DROP_DEPTH  = 3'd3,
        CFG_FADE_MAX    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]       mode;
        logic [LED_W-1:0] led;
        logic [LVL_W-1:0] target;
    } t_in;

    typedef struct packed {
        logic [LED_W-1:0] led_id;
        logic [LVL_W-1:0] fade_level;
        logic [LVL_W-1:0] mod_factor;
        logic             ramping;
        logic             last;
    } t_out;

    typedef struct packed {
        logic           start;
        logic           div_en;
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        logic [DVW-1:0] divisor;
    } t_mdu_req;

    typedef struct packed {
        logic             done;
        logic [PRODW-1:0] result;
    } t_mdu_rsp;

    function automatic logic mask_bit(input logic [MASK_W-1:0] m,
                                      input logic [LED_W-1:0] i);
        logic [7:0] e;
        e = 8'(m);
        return e[i];
    endfunction

    function automatic logic [LVL_W-1:0] pulse_curve(input logic [PULSE_W-1:0] idx);
        logic [LVL_W-1:0] v;
        unique case (idx)
            5'd0:    v = 8'd200;
            5'd1:    v = 8'd140;
            5'd2:    v = 8'd100;
            5'd3:    v = 8'd90;
            5'd4:    v = 8'd100;
            5'd5:    v = 8'd125;
            5'd6:    v = 8'd155;
            5'd7:    v = 8'd180;
            5'd8:    v = 8'd200;
            5'd9:    v = 8'd218;
            5'd10:   v = 8'd232;
            5'd11:   v = 8'd242;
            5'd12:   v = 8'd248;
            5'd13:   v = 8'd252;
            5'd14:   v = 8'd254;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[rtl/lfp_mdu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lfp_mdu
// Bit-serial multiply (one multiplier bit per cycle) with an optional
// restoring divide of the product (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module lfp_mdu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfp_pkg::t_mdu_req i_req,
    output lfp_pkg::t_mdu_rsp o_rsp
);
    import lfp_pkg::*;

    localparam int HW = OPW + 1;

    typedef enum logic [2:0] {
        M_IDLE = 3'b001,
        M_MUL  = 3'b010,
        M_DIV  = 3'b100
    } t_mstate;

    t_mstate          r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             r_div_en;
    logic [OPW-1:0]   r_a;
    logic [HW-1:0]    r_hi;
    logic [OPW-1:0]   r_lo;
    logic [DVW-1:0]   r_dvs;
    logic [DVW-1:0]   r_rem;
    logic [QW-1:0]    r_dq;

    logic [HW-1:0]    w_sum;
    logic [HW-1:0]    n_hi;
    logic [OPW-1:0]   n_lo;
    logic [PRODW-1:0] w_prod_n;
    logic [DVW:0]     w_trial;
    logic [DVW:0]     w_diff;
    logic             w_qbit;

    assign w_sum    = r_hi + (r_lo[0] ? HW'(r_a) : '0);
    assign n_hi     = {1'b0, w_sum[HW-1:1]};
    assign n_lo     = {w_sum[0], r_lo[OPW-1:1]};
    assign w_prod_n = {n_hi[OPW-1:0], n_lo};

    assign w_trial  = {r_rem, r_dq[QW-1]};
    assign w_qbit   = w_trial >= {1'b0, r_dvs};
    assign w_diff   = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_a      <= i_req.a;
                        r_lo     <= i_req.b;
                        r_hi     <= '0;
                        r_dvs    <= i_req.divisor;
                        r_div_en <= i_req.div_en;
                        r_cnt    <= '0;
                        r_state  <= M_MUL;
                    end
                end
                M_MUL: begin
                    r_hi  <= n_hi;
                    r_lo  <= n_lo;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                        r_cnt <= '0;
                        if (r_div_en) begin
                            r_dq    <= w_prod_n[QW-1:0];
                            r_rem   <= '0;
                            r_state <= M_DIV;
                        end else begin
                            r_done  <= 1'b1;
                            r_state <= M_IDLE;
                        end
                    end
                end
                M_DIV: begin
                    r_dq  <= {r_dq[QW-2:0], w_qbit};
                    r_rem <= w_qbit ? w_diff[DVW-1:0] : w_trial[DVW-1:0];
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_done  <= 1'b1;
                        r_state <= M_IDLE;
                    end
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_div_en ? PRODW'(r_dq) : {r_hi[OPW-1:0], r_lo};

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == M_IDLE)
        else $error("mdu started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("mdu done longer than one cycle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == M_IDLE)
        else $error("mdu done while busy");
`endif

endmodule
`default_nettype wire

[rtl/led_fade_pulse_breath_envelope.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// led_fade_pulse_breath_envelope
// Per-LED fade ramp, key press pulse and breathing envelope.
// ----------------------------------------------------------------------------
// A press item, an unused-mode item and a set target for an LED out of range
// are handled in the idle state alone. A set target that is ignored or whose
// level is already there returns to idle from the set state; otherwise it
// waits in the set-wait state for a ramp length from a multiply and divide.
// A tick walks over the LEDs, one result per LED. Each LED passes the factor,
// emit and advance states, plus two serial multiplies when breathing and a
// multiply and divide while a ramp runs and is not at its last step. These run
// on the shared bit-serial multiply-divide unit. Results wait in a one-deep
// output register, and a stall there holds the walk.
module led_fade_pulse_breath_envelope #(
    parameter int LEDS = lfp_pkg::LFP_LEDS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lfp_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lfp_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lfp_pkg::CFG_IDXW-1:0]  i_cfg_idx,
    input  logic [lfp_pkg::CFG_W-1:0]     i_cfg_data
);
    import lfp_pkg::*;

    localparam int IW = (LEDS > 1) ? $clog2(LEDS) : 1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SET      = 9'b000000010,
        S_SET_WAIT = 9'b000000100,
        S_FAC      = 9'b000001000,
        S_EASE1    = 9'b000010000,
        S_EASE2    = 9'b000100000,
        S_EMIT     = 9'b001000000,
        S_ADV      = 9'b010000000,
        S_ADV_WAIT = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [MASK_W-1:0]  r_breath_mask;
    logic [MASK_W-1:0]  r_press_mask;
    logic [PHASE_W-1:0] r_phase_step;
    logic [DEPTH_W-1:0] r_drop_depth;
    logic [LVL_W-1:0]   r_fade_max;

    logic [LVL_W-1:0]   r_level      [LEDS];
    logic [LVL_W-1:0]   r_goal       [LEDS];
    logic [LVL_W-1:0]   r_ramp_start [LEDS];
    logic [LVL_W-1:0]   r_ramp_end   [LEDS];
    logic [LVL_W-1:0]   r_ramp_pos   [LEDS];
    logic [LVL_W-1:0]   r_ramp_len   [LEDS];
    logic               r_ramp_on    [LEDS];
    logic [PULSE_W-1:0] r_pulse_left [LEDS];
    logic [PHASE_W-1:0] r_phase      [LEDS];

    logic [IW-1:0]      r_idx;
    logic [LVL_W-1:0]   r_tgt;
    logic [LVL_W-1:0]   r_fac;
    logic               r_ov;
    t_out               r_out;

    t_mdu_req           w_req;
    t_mdu_rsp           w_rsp;

    logic               w_accept;
    logic               w_led_ok;
    logic [IW-1:0]      w_led_idx;
    logic               w_last;
    logic               w_breath;
    logic [LVL_W-1:0]   w_lvl;
    logic [LVL_W-1:0]   w_start;
    logic [LVL_W-1:0]   w_end_lvl;
    logic               w_ignore;
    logic               w_same;
    logic [LVL_W-1:0]   w_dist;
    logic [LVL_W-1:0]   w_phb;
    logic [LVL_W-1:0]   w_x;
    logic [PULSE_W-1:0] w_pidx;
    logic [PRODW-1:0]   w_drop_r;
    logic [PRODW-8:0]   w_drop;
    logic               w_up;
    logic [LVL_W-1:0]   w_rdiff;
    logic [LVL_W:0]     w_p;
    logic               w_rend;
    logic [LVL_W-1:0]   w_q;
    logic               w_out_free;
    logic               w_out_load;
    logic [MASK_W-1:0]  w_bchg;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_led_ok   = {1'b0, i_in_data.led} < 4'(LEDS);
    assign w_led_idx  = i_in_data.led[IW-1:0];
    assign w_last     = r_idx == IW'(LEDS - 1);
    assign w_breath   = mask_bit(r_breath_mask, LED_W'(r_idx));

    assign w_lvl      = r_level[r_idx];
    assign w_start    = r_ramp_start[r_idx];
    assign w_end_lvl  = r_ramp_end[r_idx];
    assign w_ignore   = (r_tgt == r_goal[r_idx]) && (r_ramp_on[r_idx] || w_lvl == r_tgt);
    assign w_same     = w_lvl == r_tgt;
    assign w_dist     = (w_lvl > r_tgt) ? w_lvl - r_tgt : r_tgt - w_lvl;

    assign w_phb      = r_phase[r_idx][PHASE_W-1:PHASE_W-LVL_W];
    assign w_x        = w_phb[LVL_W-1] ? ~w_phb : w_phb;
    assign w_pidx     = (r_pulse_left[r_idx] > PULSE_W'(PULSE_STEPS)) ? '0
                      : PULSE_W'(PULSE_STEPS) - r_pulse_left[r_idx];
    assign w_drop_r   = w_rsp.result + EASE_ROUND;
    assign w_drop     = w_drop_r[PRODW-1:7];

    assign w_up       = w_end_lvl >= w_start;
    assign w_rdiff    = w_up ? w_end_lvl - w_start : w_start - w_end_lvl;
    assign w_p        = (LVL_W + 1)'(r_ramp_pos[r_idx]) + 1'b1;
    assign w_rend     = (r_ramp_len[r_idx] == '0) || (w_p >= (LVL_W + 1)'(r_ramp_len[r_idx]));
    assign w_q        = w_rsp.result[LVL_W-1:0];

    assign w_out_free = !r_ov || !i_out_stall;
    assign w_out_load = (r_state == S_EMIT) && w_out_free;
    assign w_bchg     = i_cfg_data[MASK_W-1:0] ^ r_breath_mask;

    always_comb begin
        w_req = '0;
        unique case (r_state)
            S_SET: begin
                w_req.start   = !w_ignore && !w_same;
                w_req.div_en  = 1'b1;
                w_req.a       = OPW'(w_dist);
                w_req.b       = OPW'(r_fade_max);
                w_req.divisor = FULL_SCALE;
            end
            S_FAC: begin
                w_req.start = w_breath;
                w_req.a     = OPW'(w_x);
                w_req.b     = OPW'(FULL_SCALE - w_x);
            end
            S_EASE1: begin
                w_req.start = w_rsp.done;
                w_req.a     = r_drop_depth;
                w_req.b     = w_rsp.result[OPW+6:7];
            end
            S_ADV: begin
                w_req.start   = r_ramp_on[r_idx] && !w_rend;
                w_req.div_en  = 1'b1;
                w_req.a       = OPW'(w_rdiff);
                w_req.b       = w_p;
                w_req.divisor = r_ramp_len[r_idx];
            end
            default: begin
                w_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_data.mode == MODE_TICK) begin
                    n_state = S_FAC;
                end else if (w_accept && i_in_data.mode == MODE_SET && w_led_ok) begin
                    n_state = S_SET;
                end
            end
            S_SET: begin
                n_state = (w_ignore || w_same) ? S_IDLE : S_SET_WAIT;
            end
            S_SET_WAIT: begin
                if (w_rsp.done) n_state = S_IDLE;
            end
            S_FAC: begin
                n_state = w_breath ? S_EASE1 : S_EMIT;
            end
            S_EASE1: begin
                if (w_rsp.done) n_state = S_EASE2;
            end
            S_EASE2: begin
                if (w_rsp.done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) n_state = S_ADV;
            end
            S_ADV: begin
                if (r_ramp_on[r_idx] && !w_rend) begin
                    n_state = S_ADV_WAIT;
                end else begin
                    n_state = w_last ? S_IDLE : S_FAC;
                end
            end
            S_ADV_WAIT: begin
                if (w_rsp.done) n_state = w_last ? S_IDLE : S_FAC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_idx         <= '0;
            r_ov          <= 1'b0;
            r_breath_mask <= BREATH_MASK_RST;
            r_press_mask  <= PRESS_MASK_RST;
            r_phase_step  <= PHASE_STEP_RST;
            r_drop_depth  <= DROP_DEPTH_RST;
            r_fade_max    <= FADE_MAX_RST;
            for (int i = 0; i < LEDS; i++) begin
                r_level[i]      <= '0;
                r_goal[i]       <= '0;
                r_ramp_start[i] <= '0;
                r_ramp_end[i]   <= '0;
                r_ramp_pos[i]   <= '0;
                r_ramp_len[i]   <= '0;
                r_ramp_on[i]    <= 1'b0;
                r_pulse_left[i] <= '0;
                r_phase[i]      <= '0;
            end
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_tgt <= i_in_data.target;
                        if (i_in_data.mode == MODE_TICK) begin
                            r_idx <= '0;
                        end else begin
                            r_idx <= w_led_idx;
                        end
                        if (i_in_data.mode == MODE_PRESS && w_led_ok
                                && mask_bit(r_press_mask, i_in_data.led)
                                && !mask_bit(r_breath_mask, i_in_data.led)) begin
                            r_pulse_left[w_led_idx] <= PULSE_W'(PULSE_STEPS);
                        end
                    end
                end
                S_SET: begin
                    if (!w_ignore) begin
                        r_goal[r_idx] <= r_tgt;
                        if (w_same) begin
                            r_ramp_on[r_idx] <= 1'b0;
                        end else begin
                            r_ramp_start[r_idx] <= w_lvl;
                            r_ramp_end[r_idx]   <= r_tgt;
                            r_ramp_pos[r_idx]   <= '0;
                        end
                    end
                end
                S_SET_WAIT: begin
                    if (w_rsp.done) begin
                        r_ramp_len[r_idx] <= (w_q == '0) ? LVL_W'(1) : w_q;
                        r_ramp_on[r_idx]  <= 1'b1;
                    end
                end
                S_FAC: begin
                    if (r_pulse_left[r_idx] != '0) begin
                        r_fac <= pulse_curve(w_pidx);
                    end else begin
                        r_fac <= FULL_SCALE;
                    end
                end
                S_EASE1: begin
                end
                S_EASE2: begin
                    if (w_rsp.done) begin
                        r_fac <= (w_drop > (PRODW-7)'(FULL_SCALE)) ? '0
                               : FULL_SCALE - w_drop[LVL_W-1:0];
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out.led_id     <= LED_W'(r_idx);
                        r_out.fade_level <= w_lvl;
                        r_out.mod_factor <= r_fac;
                        r_out.ramping    <= r_ramp_on[r_idx];
                        r_out.last       <= w_last;
                    end
                end
                S_ADV: begin
                    if (r_pulse_left[r_idx] != '0) begin
                        r_pulse_left[r_idx] <= r_pulse_left[r_idx] - 1'b1;
                    end
                    if (w_breath) begin
                        r_phase[r_idx] <= r_phase[r_idx] + r_phase_step;
                    end
                    if (r_ramp_on[r_idx]) begin
                        r_ramp_pos[r_idx] <= w_p[LVL_W-1:0];
                        if (w_rend) begin
                            r_level[r_idx]   <= w_end_lvl;
                            r_ramp_on[r_idx] <= 1'b0;
                        end
                    end
                    if (!(r_ramp_on[r_idx] && !w_rend) && !w_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_ADV_WAIT: begin
                    if (w_rsp.done) begin
                        r_level[r_idx] <= w_up ? w_start + w_q : w_start - w_q;
                        if (!w_last) r_idx <= r_idx + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BREATH_MASK: begin
                        for (int i = 0; i < LEDS; i++) begin
                            if (mask_bit(w_bchg, LED_W'(i))) begin
                                r_phase[i]      <= '0;
                                r_pulse_left[i] <= '0;
                            end
                        end
                        r_breath_mask <= i_cfg_data[MASK_W-1:0];
                    end
                    CFG_PRESS_MASK: r_press_mask <= i_cfg_data[MASK_W-1:0];
                    CFG_PHASE_STEP: r_phase_step <= i_cfg_data[PHASE_W-1:0];
                    CFG_DROP_DEPTH: r_drop_depth <= i_cfg_data[DEPTH_W-1:0];
                    CFG_FADE_MAX:   r_fade_max   <= i_cfg_data[LVL_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    lfp_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_tick_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.mode == MODE_TICK) |=> r_state == S_FAC)
        else $error("tick transfer did not start the LED walk");
    a_ramp_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADV_WAIT |-> r_ramp_on[r_idx])
        else $error("ramp divide without a running ramp");
    a_mdu_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> (r_state == S_SET || r_state == S_FAC
                         || r_state == S_EASE1 || r_state == S_ADV))
        else $error("mdu started from an unexpected state");
`endif

endmodule
`default_nettype wire

[tb/tb_led_fade_pulse_breath_envelope.sv]
// ----------------------------------------------------------------------------
// tb_led_fade_pulse_breath_envelope
// Self-checking bench for the LED fade, pulse and breathing envelope block.
// A clocked driver sends tick, set-target, press and junk items from a queue.
// Both sides insert random idle bursts. An in-bench predictor tracks ramps,
// pulses and breathing phases and checks every LED report in order. Register
// settings change between phases, and only while the block is idle.
// ----------------------------------------------------------------------------
module tb_led_fade_pulse_breath_envelope;
    import lfp_pkg::*;

    localparam int          NLED        = LFP_LEDS;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          DRAIN_PAUSE = 200;
    localparam int          PHASE_ITEMS = 58;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam logic [16*8-1:0] PRESS_CURVE = {
        8'd255, 8'd254, 8'd252, 8'd248, 8'd242, 8'd232, 8'd218, 8'd200,
        8'd180, 8'd155, 8'd125, 8'd100, 8'd90,  8'd100, 8'd140, 8'd200
    };

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in                 i_in_data = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out                o_out_data;
    logic                i_cfg_we = 1'b0;
    logic [CFG_IDXW-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    led_fade_pulse_breath_envelope DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of registers and per-LED state
    logic [MASK_W-1:0]  breath_on;
    logic [MASK_W-1:0]  press_ok;
    logic [PHASE_W-1:0] phase_inc;
    logic [DEPTH_W-1:0] dip_depth;
    logic [LVL_W-1:0]   full_ramp_ticks;
    logic [LVL_W-1:0]   lvl      [NLED];
    logic [LVL_W-1:0]   aim      [NLED];
    logic [LVL_W-1:0]   from_lvl [NLED];
    logic [LVL_W-1:0]   to_lvl   [NLED];
    logic [LVL_W-1:0]   ramp_step[NLED];
    logic [LVL_W-1:0]   ramp_span[NLED];
    logic               ramp_run [NLED];
    logic [PULSE_W-1:0] pulse_cnt[NLED];
    logic [PHASE_W-1:0] breath_ph[NLED];

    t_in                pending_items[$];
    t_out               due_reports[$];
    logic [LVL_W-1:0]   last_aim[NLED];

    logic               in_fire = 1'b0;
    logic               calm = 1'b0;
    int                 send_gap = 0;
    int                 stall_left = 0;
    int                 cycles = 0;
    int                 errors = 0;
    int                 items_taken = 0;
    int                 ticks_taken = 0;
    int                 reports_seen = 0;
    int                 settings_used = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [LVL_W-1:0] breath_level(input logic [PHASE_W-1:0] ph);
        int unsigned b;
        int unsigned x;
        int unsigned smooth;
        int unsigned drop;
        b = ph[15:8];
        x = (b < 128) ? b : 255 - b;
        smooth = (x * (255 - x)) >> 7;
        drop = (dip_depth * smooth + 64) >> 7;
        return (drop > 255) ? 8'd0 : LVL_W'(255 - drop);
    endfunction

    task automatic aim_led(input int i, input logic [LVL_W-1:0] t);
        int unsigned d;
        int unsigned len;
        if (t == aim[i] && (ramp_run[i] || lvl[i] == t))
            return;
        aim[i] = t;
        if (lvl[i] == t) begin
            ramp_run[i] = 1'b0;
            return;
        end
        from_lvl[i] = lvl[i];
        to_lvl[i] = t;
        d = (lvl[i] > t) ? lvl[i] - t : t - lvl[i];
        len = (d * full_ramp_ticks) / 255;
        ramp_span[i] = (len == 0) ? 8'd1 : LVL_W'(len);
        ramp_step[i] = '0;
        ramp_run[i] = 1'b1;
    endtask

    task automatic step_ramp(input int i);
        int unsigned s;
        int unsigned e;
        int unsigned p;
        int unsigned n;
        s = from_lvl[i];
        e = to_lvl[i];
        if (!ramp_run[i])
            return;
        p = ramp_step[i] + 1;
        n = ramp_span[i];
        ramp_step[i] = LVL_W'(p);
        if (n == 0 || p >= n) begin
            lvl[i] = to_lvl[i];
            ramp_run[i] = 1'b0;
        end else if (e >= s) begin
            lvl[i] = LVL_W'(s + ((e - s) * p) / n);
        end else begin
            lvl[i] = LVL_W'(s - ((s - e) * p) / n);
        end
    endtask

    task automatic apply_envelope_item(input t_in it);
        t_out rep;
        int   idx;
        items_taken++;
        case (it.mode)
            MODE_SET: begin
                if (it.led < NLED)
                    aim_led(it.led, it.target);
            end
            MODE_PRESS: begin
                if (it.led < NLED && press_ok[it.led] && !breath_on[it.led])
                    pulse_cnt[it.led] = PULSE_W'(PULSE_STEPS);
            end
            MODE_TICK: begin
                ticks_taken++;
                for (int i = 0; i < NLED; i++) begin
                    rep.led_id = LED_W'(i);
                    rep.fade_level = lvl[i];
                    rep.ramping = ramp_run[i];
                    rep.last = (i == NLED - 1);
                    if (breath_on[i]) begin
                        rep.mod_factor = breath_level(breath_ph[i]);
                    end else if (pulse_cnt[i] != 0) begin
                        idx = (pulse_cnt[i] > PULSE_STEPS) ? 0
                            : PULSE_STEPS - pulse_cnt[i];
                        rep.mod_factor = (idx >= 16) ? 8'd255 : PRESS_CURVE[idx*8 +: 8];
                    end else begin
                        rep.mod_factor = FULL_SCALE;
                    end
                    due_reports.push_back(rep);
                end
                for (int i = 0; i < NLED; i++) begin
                    if (pulse_cnt[i] != 0)
                        pulse_cnt[i] = pulse_cnt[i] - 1'b1;
                    if (breath_on[i])
                        breath_ph[i] = breath_ph[i] + phase_inc;
                    step_ramp(i);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_report(input t_out got);
        t_out want;
        logic bad;
        reports_seen++;
        if (due_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected report: led %0d level %0d factor %0d ramp %0d last %0d",
                         got.led_id, got.fade_level, got.mod_factor, got.ramping,
                         got.last);
            return;
        end
        want = due_reports.pop_front();
        bad = (got.led_id !== want.led_id) || (got.fade_level !== want.fade_level) ||
              (got.mod_factor !== want.mod_factor) || (got.ramping !== want.ramping) ||
              (got.last !== want.last);
        if (bad) begin
            errors++;
            if (errors <= 10) begin
                $display("report mismatch: exp led %0d lvl %0d fac %0d rmp %0d last %0d",
                         want.led_id, want.fade_level, want.mod_factor, want.ramping,
                         want.last);
                $display("                 got led %0d lvl %0d fac %0d rmp %0d last %0d",
                         got.led_id, got.fade_level, got.mod_factor, got.ramping,
                         got.last);
            end
        end
    endtask

    // sampling at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall)
                apply_envelope_item(i_in_data);
            if (o_out_valid && !i_out_stall)
                check_report(o_out_data);
        end
    end

    // item driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            // hold the stalled transfer
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            i_in_valid <= 1'b0;
        end else if (!calm && pending_items.size() != 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
            i_in_data <= pending_items.pop_front();
            i_in_valid <= 1'b1;
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        logic [MASK_W-1:0] flip;
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_BREATH_MASK: begin
                flip = val[MASK_W-1:0] ^ breath_on;
                for (int i = 0; i < NLED; i++) begin
                    if (flip[i]) begin
                        breath_ph[i] = '0;
                        pulse_cnt[i] = '0;
                    end
                end
                breath_on = val[MASK_W-1:0];
            end
            CFG_PRESS_MASK: press_ok = val[MASK_W-1:0];
            CFG_PHASE_STEP: phase_inc = val[PHASE_W-1:0];
            CFG_DROP_DEPTH: dip_depth = val[DEPTH_W-1:0];
            CFG_FADE_MAX:   full_ramp_ticks = val[LVL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_setting(input logic [2:0] bm, input logic [2:0] pm,
                                 input logic [15:0] st, input logic [8:0] dp,
                                 input logic [7:0] fm);
        settings_used++;
        write_reg(CFG_BREATH_MASK, CFG_W'(bm));
        write_reg(CFG_PRESS_MASK, CFG_W'(pm));
        write_reg(CFG_PHASE_STEP, st);
        write_reg(CFG_DROP_DEPTH, CFG_W'(dp));
        write_reg(CFG_FADE_MAX, CFG_W'(fm));
    endtask

    task automatic add_item(input logic [1:0] mode, input logic [2:0] led,
                            input logic [7:0] target);
        t_in it;
        it.mode = mode;
        it.led = led;
        it.target = target;
        pending_items.push_back(it);
        if (mode == MODE_SET && led < NLED)
            last_aim[led] = target;
    endtask

    task automatic add_random_items(input int n);
        int r;
        int k;
        int led;
        logic [7:0] t;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 48) begin
                add_item(MODE_TICK, 3'($urandom), 8'($urandom));
            end else if (r < 78) begin
                led = $urandom_range(0, NLED - 1);
                k = $urandom_range(0, 9);
                if (k == 0)
                    t = 8'd0;
                else if (k == 1)
                    t = 8'd255;
                else if (k < 4)
                    t = last_aim[led];
                else
                    t = 8'($urandom);
                add_item(MODE_SET, 3'(led), t);
            end else if (r < 92) begin
                add_item(MODE_PRESS, 3'($urandom_range(0, NLED - 1)), 8'($urandom));
            end else if (r < 96) begin
                add_item(MODE_UNUSED, 3'($urandom), 8'($urandom));
            end else begin
                add_item(($urandom_range(0, 1) != 0) ? MODE_SET : MODE_PRESS,
                         3'($urandom_range(NLED, 7)), 8'($urandom));
            end
        end
    endtask

    task automatic drain;
        while (pending_items.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (due_reports.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    initial begin
        breath_on = BREATH_MASK_RST;
        press_ok = PRESS_MASK_RST;
        phase_inc = PHASE_STEP_RST;
        dip_depth = DROP_DEPTH_RST;
        full_ramp_ticks = FADE_MAX_RST;
        for (int i = 0; i < NLED; i++) begin
            lvl[i] = '0; aim[i] = '0; from_lvl[i] = '0; to_lvl[i] = '0;
            ramp_step[i] = '0; ramp_span[i] = '0; ramp_run[i] = 1'b0;
            pulse_cnt[i] = '0; breath_ph[i] = '0; last_aim[i] = '0;
        end
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // directed: ramps, same target, already there, refused and junk items
        write_setting(3'b100, 3'b011, 16'hFFFF, 9'd511, 8'd255);
        add_item(MODE_TICK, 3'd0, 8'd0);
        add_item(MODE_SET, 3'd0, 8'd200);
        add_item(MODE_SET, 3'd0, 8'd0);
        add_item(MODE_SET, 3'd0, 8'd255);
        add_item(MODE_SET, 3'd0, 8'd255);
        add_item(MODE_SET, 3'd1, 8'd0);
        add_item(MODE_SET, 3'd1, 8'd1);
        add_item(MODE_PRESS, 3'd0, 8'd0);
        add_item(MODE_PRESS, 3'd1, 8'd0);
        add_item(MODE_PRESS, 3'd2, 8'd0);
        add_item(MODE_PRESS, 3'd7, 8'd255);
        add_item(MODE_SET, 3'd5, 8'd77);
        add_item(MODE_UNUSED, 3'd7, 8'd255);
        add_item(MODE_TICK, 3'd7, 8'd255);
        add_item(MODE_TICK, 3'd0, 8'd0);
        add_item(MODE_SET, 3'd2, 8'd128);
        add_item(MODE_TICK, 3'd0, 8'd0);
        add_item(MODE_PRESS, 3'd0, 8'd0);
        add_item(MODE_SET, 3'd1, 8'd0);
        repeat (5) add_item(MODE_TICK, 3'd0, 8'd0);
        drain();

        write_setting(3'b011, 3'b111, 16'd0, 9'd0, 8'd1);
        add_random_items(PHASE_ITEMS);
        drain();

        write_setting(3'b000, 3'b111, 16'd1, 9'd257, 8'd0);
        add_random_items(PHASE_ITEMS);
        drain();

        write_setting(3'b111, 3'b101, 16'd4096, 9'd171, 8'd20);
        add_random_items(PHASE_ITEMS);
        drain();

        write_setting(3'b010, 3'b110, 16'($urandom), 9'($urandom), 8'($urandom_range(1, 255)));
        add_random_items(PHASE_ITEMS);
        drain();

        calm = 1'b1;
        write_setting(3'b101, 3'b111, 16'd218, 9'd128, 8'd12);
        add_random_items(PHASE_ITEMS);
        drain();

        $display("%0d items (%0d ticks) sent under %0d register settings",
                 items_taken, ticks_taken, settings_used);
        $display("%0d LED reports checked, %0d mismatches", reports_seen, errors);
        if (errors == 0 && due_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

[led_fade_pulse_breath_envelope.f]
rtl/lfp_pkg.sv
rtl/lfp_mdu.sv
rtl/led_fade_pulse_breath_envelope.sv
tb/tb_led_fade_pulse_breath_envelope.sv
